// ----- sv/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned InPrioW = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutCountW = 5;

  // Result status codes
  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StRemoved = 2'd1;
  localparam logic [StatusW-1:0] StUnderflow = 2'd2;
  localparam logic [StatusW-1:0] StOverflow = 2'd3;

  // Operation broadcast to every cell in the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; #(
  parameter int PRIO_W = 8
) (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic                     occupied_i,
  input  logic signed [ValueW-1:0] new_value_i,
  input  logic [PRIO_W-1:0]        new_prio_i,
  input  logic signed [ValueW-1:0] left_value_i,
  input  logic [PRIO_W-1:0]        left_prio_i,
  input  logic                     left_yield_i,
  input  logic signed [ValueW-1:0] right_value_i,
  input  logic [PRIO_W-1:0]        right_prio_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [PRIO_W-1:0]        prio_o,
  output logic                     yield_o
);

  logic signed [ValueW-1:0] value_q, value_d;
  logic [PRIO_W-1:0]        prio_q, prio_d;

  // Yield the slot when empty or holding a strictly larger priority number
  assign yield_o = !occupied_i || (prio_q > new_prio_i);

  // Shift toward head on remove; on insert take the left entry or the new one
  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    priority if (cmd_i.rem) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end else if (cmd_i.ins) begin
      if (left_yield_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (yield_o) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ----- sv/stable_priority_queue_core.sv -----
// Top level of the stable priority queue: cell chain, count and result register.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, mode_i, item_value_i,  | sink
//          | item_priority_i                               |
//  out     | out_valid_o, out_ready_i, status_o,            | source
//          | removed_value_o, entry_count_o                 |
//
// For each item, every cell compares the new priority against its own entry in
// parallel and the whole chain shifts in the cycle the item is accepted.
// The result appears in the output register on the next cycle.
// A new item is taken while the output register is empty or being drained.
// Reset empties the queue; entry contents are not cleared.
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic signed [ValueW-1:0]    item_value_i,
  input  logic [InPrioW-1:0]          item_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [StatusW-1:0]          status_o,
  output logic signed [ValueW-1:0]    removed_value_o,
  output logic [OutCountW-1:0]        entry_count_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q;
  logic [StatusW-1:0]       status_q, status_d;
  logic signed [ValueW-1:0] removed_q, removed_d;
  logic [CntW-1:0]          res_count_q;

  logic                     accept, full, empty, do_ins, do_rem;
  logic [PRIORITY_BITS+InPrioW-1:0] prio_ext;
  logic [PRIORITY_BITS-1:0] new_prio;
  cell_cmd_t                cmd;

  logic signed [ValueW-1:0] cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
  logic                     cell_yield [DEPTH];
  logic                     occupied   [DEPTH];

  logic [CntW+OutCountW-1:0] count_ext;

  // Decode the operation
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign do_ins     = accept && !mode_i && !full;
  assign do_rem     = accept && mode_i && !empty;
  assign cmd        = '{ins: do_ins, rem: do_rem};

  // Mask the priority to its configured width
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, item_priority_i};
  assign new_prio = prio_ext[PRIORITY_BITS-1:0];

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] left_value, right_value;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;
    logic                     left_yield;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_prio  = '0;
      assign left_yield = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
      assign left_yield = cell_yield[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_W(PRIORITY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied[i]),
      .new_value_i  (item_value_i),
      .new_prio_i   (new_prio),
      .left_value_i (left_value),
      .left_prio_i  (left_prio),
      .left_yield_i (left_yield),
      .right_value_i(right_value),
      .right_prio_i (right_prio),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i]),
      .yield_o      (cell_yield[i])
    );
  end

  // Advance the count and form the result
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    if (mode_i) begin
      if (empty) begin
        status_d = StUnderflow;
      end else begin
        status_d  = StRemoved;
        removed_d = cell_value[0];
        count_d   = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        status_d = StOverflow;
      end else begin
        status_d = StInserted;
        count_d  = count_q + CntW'(1);
      end
    end
  end

  // Hold the count and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      res_count_q <= count_d;
    end
  end

  assign count_ext       = {{OutCountW{1'b0}}, res_count_q};
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_ext[OutCountW-1:0];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the stable priority queue core: directed table, then random traffic.
module tb_top;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int PrioBits = 8;
  localparam int DirectedLen = 24;
  localparam int RandomPerPhase = 600;
  localparam int CycleLimit = 200000;
  localparam int MaxReports = 10;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_mode_e;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] value;
    logic [OutCountW-1:0]     count;
  } queue_result_t;

  // One stimulus row; typed rows carry their own expected result
  typedef struct {
    op_mode_e                 mode;
    logic signed [ValueW-1:0] value;
    logic [InPrioW-1:0]       prio;
    bit                       typed;
    logic [StatusW-1:0]       exp_status;
    logic signed [ValueW-1:0] exp_value;
    logic [OutCountW-1:0]     exp_count;
  } op_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     mode_i = 1'b0;
  logic signed [ValueW-1:0] item_value_i = '0;
  logic [InPrioW-1:0]       item_priority_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [StatusW-1:0]       status_o;
  logic signed [ValueW-1:0] removed_value_o;
  logic [OutCountW-1:0]     entry_count_o;

  // Expected result that travels with the item of a typed row
  bit                       fixed_valid = 1'b0;
  logic [StatusW-1:0]       fixed_status = '0;
  logic signed [ValueW-1:0] fixed_value = '0;
  logic [OutCountW-1:0]     fixed_count = '0;

  // Shadow copy of the queue contents
  logic signed [ValueW-1:0] shadow_values [Depth];
  logic [InPrioW-1:0]       shadow_prios [Depth];
  int                       shadow_count = 0;

  queue_result_t            pending_results [$];
  int                       mismatch_count = 0;
  int                       cycle_count = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;
  op_row_t                  directed_ops [DirectedLen];

  stable_priority_queue_core #(
    .DEPTH(Depth),
    .PRIORITY_BITS(PrioBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .item_value_i(item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one operation to the shadow queue and return its result
  function automatic queue_result_t apply_queue_op(input logic mode,
                                                   input logic signed [ValueW-1:0] value,
                                                   input logic [InPrioW-1:0] prio);
    queue_result_t res;
    int pos;
    int i;
    res.value = '0;
    if (mode == OpInsert) begin
      if (shadow_count >= Depth) begin
        res.status = StOverflow;
      end else begin
        // Land after every entry of lower or equal priority
        pos = 0;
        while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_values[i] = shadow_values[i-1];
          shadow_prios[i] = shadow_prios[i-1];
        end
        shadow_values[pos] = value;
        shadow_prios[pos] = prio;
        shadow_count++;
        res.status = StInserted;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = StUnderflow;
      end else begin
        res.value = shadow_values[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_values[i-1] = shadow_values[i];
          shadow_prios[i-1] = shadow_prios[i];
        end
        shadow_count--;
        res.status = StRemoved;
      end
    end
    res.count = shadow_count[OutCountW-1:0];
    return res;
  endfunction

  // Present one item after a random gap and hold it until taken
  task automatic drive_op(input op_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= row.mode;
    item_value_i <= row.value;
    item_priority_i <= row.prio;
    fixed_valid <= row.typed;
    fixed_status <= row.exp_status;
    fixed_value <= row.exp_value;
    fixed_count <= row.exp_count;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict on accepted items, check accepted results
  always @(posedge clk_i) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, removed_value_o, entry_count_o};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("unexpected result: status %0d value %0d count %0d",
                     got.status, got.value, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display("mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                       want.status, want.value, want.count,
                       got.status, got.value, got.count);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = apply_queue_op(mode_i, item_value_i, item_priority_i);
        if (fixed_valid) want = '{fixed_status, fixed_value, fixed_count};
        pending_results.push_back(want);
      end
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    op_row_t row;
    int k;
    int phase;
    int n;
    int insert_bias;

    // Typed rows: empty, extremes, error codes; the rest are checked against the shadow queue
    directed_ops[0]  = '{OpRemove, 32'sd0, 8'd0, 1'b1, StUnderflow, 32'sd0, 5'd0};
    directed_ops[1]  = '{OpInsert, 32'sh7FFFFFFF, 8'hFF, 1'b1, StInserted, 32'sd0, 5'd1};
    directed_ops[2]  = '{OpInsert, 32'sh80000000, 8'h00, 1'b1, StInserted, 32'sd0, 5'd2};
    directed_ops[3]  = '{OpRemove, 32'sd0, 8'd0, 1'b1, StRemoved, 32'sh80000000, 5'd1};
    directed_ops[4]  = '{OpRemove, 32'sd0, 8'd0, 1'b1, StRemoved, 32'sh7FFFFFFF, 5'd0};
    // Fill to capacity with ties spread through the list
    directed_ops[5]  = '{OpInsert, 32'sd11, 8'd5, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[6]  = '{OpInsert, 32'sd12, 8'd5, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[7]  = '{OpInsert, 32'sd13, 8'd4, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[8]  = '{OpInsert, -32'sd1, 8'd5, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[9]  = '{OpInsert, 32'sd15, 8'hFF, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[10] = '{OpInsert, 32'sd16, 8'h00, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[11] = '{OpInsert, 32'sd17, 8'hFF, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[12] = '{OpInsert, 32'sd18, 8'h00, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[13] = '{OpInsert, 32'sd19, 8'd7, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[14] = '{OpInsert, 32'sd20, 8'd7, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[15] = '{OpInsert, 32'sd21, 8'd7, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[16] = '{OpInsert, 32'sd22, 8'd1, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[17] = '{OpInsert, 32'sd23, 8'd128, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[18] = '{OpInsert, 32'sd24, 8'd3, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[19] = '{OpInsert, 32'sd25, 8'd3, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[20] = '{OpInsert, 32'sd26, 8'd5, 1'b0, StInserted, 32'sd0, 5'd0};
    directed_ops[21] = '{OpInsert, 32'sh12345678, 8'd2, 1'b1, StOverflow, 32'sd0, 5'd16};
    // Remove with junk in the ignored fields
    directed_ops[22] = '{OpRemove, 32'shDEADBEEF, 8'hFF, 1'b0, StRemoved, 32'sd0, 5'd0};
    directed_ops[23] = '{OpRemove, 32'sd0, 8'd0, 1'b0, StRemoved, 32'sd0, 5'd0};

    // Hold reset, release on an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 46;
    for (k = 0; k < DirectedLen; k++) drive_op(directed_ops[k]);

    // Random traffic under three idle profiles
    insert_bias = 50;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < RandomPerPhase; n++) begin
        // Drift toward full or empty in bursts
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: insert_bias = 15;
            1: insert_bias = 50;
            default: insert_bias = 85;
          endcase
        end
        row.mode = ($urandom_range(99) < insert_bias) ? OpInsert : OpRemove;
        row.value = $urandom();
        case ($urandom_range(3))
          0: row.prio = InPrioW'($urandom_range(3));
          1: row.prio = InPrioW'($urandom_range(255));
          2: row.prio = $urandom_range(1) ? 8'hFF : 8'h00;
          default: row.prio = InPrioW'($urandom_range(15));
        endcase
        row.typed = 1'b0;
        row.exp_status = StInserted;
        row.exp_value = '0;
        row.exp_count = '0;
        drive_op(row);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then idle briefly before reporting
    recv_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
